>>> rtl/aomp_pkg.sv
// Shared constants for the assembler operand mode parser: phases, radix, status and mode codes.
package aomp_pkg;

	// Parser phase codes
	localparam logic [3:0] PH_START  = 4'd0;
	localparam logic [3:0] PH_BASE   = 4'd1;
	localparam logic [3:0] PH_QUOTE  = 4'd2;
	localparam logic [3:0] PH_DIGITS = 4'd3;
	localparam logic [3:0] PH_AFTER  = 4'd4;
	localparam logic [3:0] PH_COMMA  = 4'd5;
	localparam logic [3:0] PH_REG    = 4'd6;
	localparam logic [3:0] PH_TRAIL  = 4'd7;
	localparam logic [3:0] PH_ERR    = 4'd8;

	// Radix codes
	localparam logic [1:0] RADIX_BIN = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;
	localparam logic [1:0] RADIX_DEC = 2'd2;
	localparam logic [1:0] RADIX_HEX = 2'd3;

	// Result status codes
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_NOT_NUM   = 4'd1;
	localparam logic [3:0] ST_IMM_INDEX = 4'd2;
	localparam logic [3:0] ST_NO_REG    = 4'd3;
	localparam logic [3:0] ST_EXTRA     = 4'd4;
	localparam logic [3:0] ST_BAD_REG   = 4'd5;
	localparam logic [3:0] ST_TOO_BIG   = 4'd6;
	localparam logic [3:0] ST_OFS_BIG   = 4'd7;
	localparam logic [3:0] ST_TRAIL     = 4'd8;

	// Addressing mode codes
	localparam logic [2:0] MODE_IMM = 3'd0;
	localparam logic [2:0] MODE_DIR = 3'd1;
	localparam logic [2:0] MODE_EXT = 3'd2;
	localparam logic [2:0] MODE_IDX = 3'd3;
	localparam logic [2:0] MODE_IDY = 3'd4;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_DOLR  = 8'h24;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	localparam logic [15:0] BYTE_MAX = 16'h00FF;
	localparam logic [3:0]  NO_DIGIT = 4'd0;

endpackage

>>> rtl/asm_operand_mode_parser_top.sv
// Assembler operand mode parser: character stream in, one status/value/mode word per operand out.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------
//  input   | in  | in_valid / in_ready  | ch[7:0]
//  result  | out | out_valid / out_ready| status[3:0] value[15:0]
//          |     |                      | addr_mode[2:0] bad_char[7:0]
//
// One character is taken per cycle while in_ready is high; parser state updates at the accepting edge.
// A NUL word loads the result register; the result is offered the next cycle.
// The result register parts the channels: input is taken while the result is
// unread only if out_ready is high in that cycle.
// Reset (arst_n low) returns the parser to the start of an operand and empties
// the result register.
module asm_operand_mode_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic [15:0] value,
	output logic [2:0]  addr_mode,
	output logic [7:0]  bad_char
);

	// Parser state
	logic [3:0]  phase_q, phase_d;
	logic [1:0]  radix_q, radix_d;
	logic [15:0] accum_q, accum_d;
	logic        over_q, over_d;
	logic        imm_q, imm_d;
	logic [7:0]  idx_q, idx_d;
	logic [3:0]  perr_q, perr_d;
	logic [7:0]  echar_q, echar_d;

	// Result register
	logic        out_valid_q;
	logic [3:0]  status_q;
	logic [15:0] value_q;
	logic [2:0]  mode_q;
	logic [7:0]  bad_q;

	logic accept, term;
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign term     = (ch == aomp_pkg::CH_NUL);

	// Digit decode and radix check
	logic       is_digit;
	logic [3:0] dval;
	logic       dig_ok;
	always_comb begin
		is_digit = 1'b1;
		dval     = aomp_pkg::NO_DIGIT;
		if (ch >= aomp_pkg::CH_0 && ch <= aomp_pkg::CH_9)
			dval = 4'(ch - aomp_pkg::CH_0);
		else if (ch >= aomp_pkg::CH_LA && ch <= aomp_pkg::CH_LF)
			dval = 4'(ch - aomp_pkg::CH_LA + 8'd10);
		else if (ch >= aomp_pkg::CH_UA && ch <= aomp_pkg::CH_UF)
			dval = 4'(ch - aomp_pkg::CH_UA + 8'd10);
		else
			is_digit = 1'b0;
		case (radix_q)
			aomp_pkg::RADIX_BIN: dig_ok = is_digit && dval < 4'd2;
			aomp_pkg::RADIX_OCT: dig_ok = is_digit && dval < 4'd8;
			aomp_pkg::RADIX_DEC: dig_ok = is_digit && dval < 4'd10;
			aomp_pkg::RADIX_HEX: dig_ok = is_digit;
			default:             dig_ok = 1'b0;
		endcase
	end

	// Multiply-add by the radix; only decimal is reached from the first digit
	logic [1:0]  mac_radix;
	logic [3:0]  mac_d;
	logic [20:0] acc_w, prod, full;
	always_comb begin
		acc_w = {5'd0, accum_q};
		case (mac_radix)
			aomp_pkg::RADIX_BIN: prod = acc_w << 1;
			aomp_pkg::RADIX_OCT: prod = acc_w << 3;
			aomp_pkg::RADIX_DEC: prod = (acc_w << 3) + (acc_w << 1);
			default:             prod = acc_w << 4;
		endcase
		full = prod + {17'd0, mac_d};
	end

	logic first_dig, blank;
	assign first_dig = (ch >= aomp_pkg::CH_1 && ch <= aomp_pkg::CH_9);
	assign blank     = (ch == aomp_pkg::CH_SPACE) || (ch == aomp_pkg::CH_TAB);
	assign mac_radix = (phase_q == aomp_pkg::PH_DIGITS) ? radix_q : aomp_pkg::RADIX_DEC;
	assign mac_d     = (phase_q == aomp_pkg::PH_DIGITS) ? dval : 4'(ch - aomp_pkg::CH_0);

	// Next parser state for one accepted character
	always_comb begin
		logic do_base, do_after, do_add;
		do_base  = 1'b0;
		do_after = 1'b0;
		do_add   = 1'b0;
		phase_d  = phase_q;
		radix_d  = radix_q;
		accum_d  = accum_q;
		over_d   = over_q;
		imm_d    = imm_q;
		idx_d    = idx_q;
		perr_d   = perr_q;
		echar_d  = echar_q;
		if (term) begin
			phase_d = aomp_pkg::PH_START;
			radix_d = aomp_pkg::RADIX_DEC;
			accum_d = '0;
			over_d  = 1'b0;
			imm_d   = 1'b0;
			idx_d   = '0;
			perr_d  = aomp_pkg::ST_OK;
			echar_d = '0;
		end else begin
			case (phase_q)
				aomp_pkg::PH_START: begin
					if (ch == aomp_pkg::CH_HASH) begin
						imm_d   = 1'b1;
						phase_d = aomp_pkg::PH_BASE;
					end else
						do_base = 1'b1;
				end
				aomp_pkg::PH_BASE:   do_base = 1'b1;
				aomp_pkg::PH_QUOTE: begin
					accum_d = {8'd0, ch};
					phase_d = aomp_pkg::PH_AFTER;
				end
				aomp_pkg::PH_DIGITS: begin
					if (dig_ok)
						do_add = 1'b1;
					else
						do_after = 1'b1;
				end
				aomp_pkg::PH_AFTER:  do_after = 1'b1;
				aomp_pkg::PH_COMMA: begin
					idx_d   = ch;
					phase_d = aomp_pkg::PH_REG;
				end
				aomp_pkg::PH_REG: begin
					perr_d  = aomp_pkg::ST_EXTRA;
					echar_d = ch;
					phase_d = aomp_pkg::PH_ERR;
				end
				aomp_pkg::PH_TRAIL: begin
					if (perr_q == aomp_pkg::ST_OK && !blank) begin
						perr_d  = aomp_pkg::ST_TRAIL;
						echar_d = ch;
					end
				end
				default: ;
			endcase

			// Radix prefix or first decimal digit
			if (do_base) begin
				if (ch == aomp_pkg::CH_PCT) begin
					radix_d = aomp_pkg::RADIX_BIN;
					phase_d = aomp_pkg::PH_DIGITS;
				end else if (ch == aomp_pkg::CH_AT) begin
					radix_d = aomp_pkg::RADIX_OCT;
					phase_d = aomp_pkg::PH_DIGITS;
				end else if (ch == aomp_pkg::CH_DOLR) begin
					radix_d = aomp_pkg::RADIX_HEX;
					phase_d = aomp_pkg::PH_DIGITS;
				end else if (ch == aomp_pkg::CH_QUOTE) begin
					phase_d = aomp_pkg::PH_QUOTE;
				end else if (first_dig) begin
					radix_d = aomp_pkg::RADIX_DEC;
					phase_d = aomp_pkg::PH_DIGITS;
					do_add  = 1'b1;
				end else begin
					perr_d  = aomp_pkg::ST_NOT_NUM;
					echar_d = ch;
					phase_d = aomp_pkg::PH_ERR;
				end
			end

			// Accumulate one digit, sticky over-range
			if (do_add) begin
				if (full > 21'h00FFFF)
					over_d = 1'b1;
				accum_d = full[15:0];
			end

			// First character past the number
			if (do_after) begin
				if (ch == aomp_pkg::CH_COMMA) begin
					if (imm_q) begin
						perr_d  = aomp_pkg::ST_IMM_INDEX;
						echar_d = '0;
						phase_d = aomp_pkg::PH_ERR;
					end else
						phase_d = aomp_pkg::PH_COMMA;
				end else begin
					phase_d = aomp_pkg::PH_TRAIL;
					if (!blank) begin
						perr_d  = aomp_pkg::ST_TRAIL;
						echar_d = ch;
					end
				end
			end
		end
	end

	// Result from the state left before the terminator
	logic [3:0] fin_status;
	logic [2:0] fin_mode;
	logic [7:0] fin_bad;
	logic       big, reg_ok;
	always_comb begin
		big        = accum_q > aomp_pkg::BYTE_MAX;
		reg_ok     = (idx_q == aomp_pkg::CH_X) || (idx_q == aomp_pkg::CH_Y);
		fin_status = aomp_pkg::ST_OK;
		fin_mode   = aomp_pkg::MODE_IMM;
		fin_bad    = '0;
		if (phase_q == aomp_pkg::PH_START || phase_q == aomp_pkg::PH_BASE)
			fin_status = aomp_pkg::ST_NOT_NUM;
		else if (phase_q == aomp_pkg::PH_COMMA)
			fin_status = aomp_pkg::ST_NO_REG;
		else if (phase_q == aomp_pkg::PH_REG && !reg_ok) begin
			fin_status = aomp_pkg::ST_BAD_REG;
			fin_bad    = idx_q;
		end else if (phase_q == aomp_pkg::PH_ERR) begin
			fin_status = perr_q;
			fin_bad    = echar_q;
		end else if (over_q)
			fin_status = aomp_pkg::ST_TOO_BIG;
		else begin
			if (phase_q == aomp_pkg::PH_REG)
				fin_mode = (idx_q == aomp_pkg::CH_X) ? aomp_pkg::MODE_IDX : aomp_pkg::MODE_IDY;
			else if (imm_q)
				fin_mode = aomp_pkg::MODE_IMM;
			else
				fin_mode = big ? aomp_pkg::MODE_EXT : aomp_pkg::MODE_DIR;
			if (phase_q == aomp_pkg::PH_REG && big)
				fin_status = aomp_pkg::ST_OFS_BIG;
			else if (perr_q == aomp_pkg::ST_TRAIL) begin
				fin_status = aomp_pkg::ST_TRAIL;
				fin_bad    = echar_q;
			end
		end
		if (fin_status != aomp_pkg::ST_OK)
			fin_mode = aomp_pkg::MODE_IMM;
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= aomp_pkg::PH_START;
			radix_q <= aomp_pkg::RADIX_DEC;
			accum_q <= '0;
			over_q  <= 1'b0;
			imm_q   <= 1'b0;
			idx_q   <= '0;
			perr_q  <= aomp_pkg::ST_OK;
			echar_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			radix_q <= radix_d;
			accum_q <= accum_d;
			over_q  <= over_d;
			imm_q   <= imm_d;
			idx_q   <= idx_d;
			perr_q  <= perr_d;
			echar_q <= echar_d;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept && term)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (accept && term) begin
			status_q <= fin_status;
			value_q  <= accum_q;
			mode_q   <= fin_mode;
			bad_q    <= fin_bad;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value     = value_q;
	assign addr_mode = mode_q;
	assign bad_char  = bad_q;

	// A terminator always yields a result in the next cycle
	a_term_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept && term |=> out_valid_q)
		else $error("terminator did not load a result");

	// Input stalls only behind an unread result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid_q)
		else $error("input stalled with empty result register");

	// Start of operand holds a cleared accumulator
	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == aomp_pkg::PH_START |-> accum_q == 16'd0 && !over_q && !imm_q
			&& perr_q == aomp_pkg::ST_OK)
		else $error("operand start with stale state");

	// Failed operands carry no mode
	a_err_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != aomp_pkg::ST_OK |-> mode_q == aomp_pkg::MODE_IMM)
		else $error("mode set on failed operand");

	// Good operands name no character
	a_ok_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == aomp_pkg::ST_OK |-> bad_q == 8'd0)
		else $error("bad_char set on good operand");

endmodule

>>> test/asm_operand_mode_parser_top_tb.sv
// Testbench for the operand mode parser: directed and random operands, checked word by word.
module asm_operand_mode_parser_top_tb;

	localparam int CHAR_TARGET    = 1150;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 20;
	localparam int REPORT_MAX     = 10;

	typedef struct packed {
		logic [3:0]  status;
		logic [15:0] value;
		logic [2:0]  addr_mode;
		logic [7:0]  bad_char;
	} operand_word_t;

	// Operand parser mirror plus the queue of words it predicts
	class operand_scoreboard;
		logic [3:0]  phase;
		logic [1:0]  radix;
		logic [15:0] accum;
		logic        over_range;
		logic        imm_seen;
		logic [7:0]  reg_char;
		logic [3:0]  pend_status;
		logic [7:0]  pend_char;
		operand_word_t parsed_words_q[$];
		int errors;
		int checked;
		logic [8:0] status_seen;
		logic [4:0] mode_seen;

		function new();
			errors = 0;
			checked = 0;
			status_seen = '0;
			mode_seen = '0;
			clear_operand();
		endfunction

		function void clear_operand();
			phase = aomp_pkg::PH_START;
			radix = aomp_pkg::RADIX_DEC;
			accum = '0;
			over_range = 1'b0;
			imm_seen = 1'b0;
			reg_char = aomp_pkg::CH_NUL;
			pend_status = aomp_pkg::ST_OK;
			pend_char = aomp_pkg::CH_NUL;
		endfunction

		function int radix_base(logic [1:0] r);
			case (r)
				aomp_pkg::RADIX_BIN: radix_base = 2;
				aomp_pkg::RADIX_OCT: radix_base = 8;
				aomp_pkg::RADIX_DEC: radix_base = 10;
				default:             radix_base = 16;
			endcase
		endfunction

		// 16 means "not a digit in any radix"
		function int digit_val(logic [7:0] c);
			if (c >= aomp_pkg::CH_0 && c <= aomp_pkg::CH_9)
				digit_val = c - aomp_pkg::CH_0;
			else if (c >= aomp_pkg::CH_LA && c <= aomp_pkg::CH_LF)
				digit_val = c - aomp_pkg::CH_LA + 10;
			else if (c >= aomp_pkg::CH_UA && c <= aomp_pkg::CH_UF)
				digit_val = c - aomp_pkg::CH_UA + 10;
			else
				digit_val = 16;
		endfunction

		function bit blank_ch(logic [7:0] c);
			blank_ch = (c == aomp_pkg::CH_SPACE) || (c == aomp_pkg::CH_TAB);
		endfunction

		function void raise_error(logic [3:0] code, logic [7:0] c);
			pend_status = code;
			pend_char = c;
			phase = aomp_pkg::PH_ERR;
		endfunction

		function void add_digit(int d);
			int full;
			full = accum * radix_base(radix) + d;
			if (full > 'hFFFF)
				over_range = 1'b1;
			accum = full[15:0];
		endfunction

		// Comma opens the index field, anything else closes the number
		function void end_of_number(logic [7:0] c);
			if (c == aomp_pkg::CH_COMMA) begin
				if (imm_seen)
					raise_error(aomp_pkg::ST_IMM_INDEX, aomp_pkg::CH_NUL);
				else
					phase = aomp_pkg::PH_COMMA;
			end else begin
				phase = aomp_pkg::PH_TRAIL;
				if (!blank_ch(c)) begin
					pend_status = aomp_pkg::ST_TRAIL;
					pend_char = c;
				end
			end
		endfunction

		// Result word for the operand that a NUL closes
		function operand_word_t close_operand();
			operand_word_t w;
			bit indexed;
			w.status = aomp_pkg::ST_OK;
			w.addr_mode = aomp_pkg::MODE_IMM;
			w.bad_char = aomp_pkg::CH_NUL;
			w.value = accum;
			if (phase == aomp_pkg::PH_START || phase == aomp_pkg::PH_BASE) begin
				w.status = aomp_pkg::ST_NOT_NUM;
			end else if (phase == aomp_pkg::PH_COMMA) begin
				w.status = aomp_pkg::ST_NO_REG;
			end else if (phase == aomp_pkg::PH_REG && reg_char != aomp_pkg::CH_X &&
				reg_char != aomp_pkg::CH_Y) begin
				w.status = aomp_pkg::ST_BAD_REG;
				w.bad_char = reg_char;
			end else if (phase == aomp_pkg::PH_ERR) begin
				w.status = pend_status;
				w.bad_char = pend_char;
			end else if (over_range) begin
				w.status = aomp_pkg::ST_TOO_BIG;
			end else begin
				if (phase == aomp_pkg::PH_REG)
					w.addr_mode = (reg_char == aomp_pkg::CH_X) ?
						aomp_pkg::MODE_IDX : aomp_pkg::MODE_IDY;
				else if (imm_seen)
					w.addr_mode = aomp_pkg::MODE_IMM;
				else
					w.addr_mode = (accum > aomp_pkg::BYTE_MAX) ?
						aomp_pkg::MODE_EXT : aomp_pkg::MODE_DIR;
				indexed = (w.addr_mode == aomp_pkg::MODE_IDX) ||
					(w.addr_mode == aomp_pkg::MODE_IDY);
				if (indexed && accum > aomp_pkg::BYTE_MAX) begin
					w.status = aomp_pkg::ST_OFS_BIG;
				end else if (pend_status == aomp_pkg::ST_TRAIL) begin
					w.status = aomp_pkg::ST_TRAIL;
					w.bad_char = pend_char;
				end
			end
			if (w.status != aomp_pkg::ST_OK)
				w.addr_mode = aomp_pkg::MODE_IMM;
			return w;
		endfunction

		// One accepted input word
		function void note_char(logic [7:0] c);
			int d;
			if (c == aomp_pkg::CH_NUL) begin
				parsed_words_q.push_back(close_operand());
				clear_operand();
			end else begin
				case (phase)
					aomp_pkg::PH_START, aomp_pkg::PH_BASE: begin
						if (phase == aomp_pkg::PH_START && c == aomp_pkg::CH_HASH) begin
							imm_seen = 1'b1;
							phase = aomp_pkg::PH_BASE;
						end else if (c == aomp_pkg::CH_PCT) begin
							radix = aomp_pkg::RADIX_BIN;
							phase = aomp_pkg::PH_DIGITS;
						end else if (c == aomp_pkg::CH_AT) begin
							radix = aomp_pkg::RADIX_OCT;
							phase = aomp_pkg::PH_DIGITS;
						end else if (c == aomp_pkg::CH_DOLR) begin
							radix = aomp_pkg::RADIX_HEX;
							phase = aomp_pkg::PH_DIGITS;
						end else if (c == aomp_pkg::CH_QUOTE) begin
							phase = aomp_pkg::PH_QUOTE;
						end else if (c >= aomp_pkg::CH_1 && c <= aomp_pkg::CH_9) begin
							radix = aomp_pkg::RADIX_DEC;
							phase = aomp_pkg::PH_DIGITS;
							add_digit(c - aomp_pkg::CH_0);
						end else begin
							raise_error(aomp_pkg::ST_NOT_NUM, c);
						end
					end
					aomp_pkg::PH_QUOTE: begin
						accum = {8'h00, c};
						phase = aomp_pkg::PH_AFTER;
					end
					aomp_pkg::PH_DIGITS: begin
						d = digit_val(c);
						if (d < radix_base(radix))
							add_digit(d);
						else
							end_of_number(c);
					end
					aomp_pkg::PH_AFTER: end_of_number(c);
					aomp_pkg::PH_COMMA: begin
						reg_char = c;
						phase = aomp_pkg::PH_REG;
					end
					aomp_pkg::PH_REG: raise_error(aomp_pkg::ST_EXTRA, c);
					aomp_pkg::PH_TRAIL: begin
						if (pend_status == aomp_pkg::ST_OK && !blank_ch(c)) begin
							pend_status = aomp_pkg::ST_TRAIL;
							pend_char = c;
						end
					end
					default: ;
				endcase
			end
		endfunction

		// One accepted result word against the oldest prediction
		function void check_result(operand_word_t got);
			operand_word_t exp_w;
			checked++;
			if (parsed_words_q.size() == 0) begin
				if (errors < REPORT_MAX)
					$display("unexpected result word: status %0d value %h mode %0d bad %h",
						got.status, got.value, got.addr_mode, got.bad_char);
				errors++;
			end else begin
				exp_w = parsed_words_q.pop_front();
				status_seen[exp_w.status] = 1'b1;
				if (exp_w.status == aomp_pkg::ST_OK)
					mode_seen[exp_w.addr_mode] = 1'b1;
				if (got.status !== exp_w.status || got.value !== exp_w.value ||
					got.addr_mode !== exp_w.addr_mode || got.bad_char !== exp_w.bad_char) begin
					if (errors < REPORT_MAX) begin
						$display("result %0d mismatch (status value mode bad_char):", checked);
						$display("  exp %0d %h %0d %h, got %0d %h %0d %h",
							exp_w.status, exp_w.value, exp_w.addr_mode, exp_w.bad_char,
							got.status, got.value, got.addr_mode, got.bad_char);
					end
					errors++;
				end
			end
		endfunction

		function int outstanding();
			return parsed_words_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [7:0]  ch        = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  status;
	logic [15:0] value;
	logic [2:0]  addr_mode;
	logic [7:0]  bad_char;

	operand_scoreboard sb;
	int chars_sent = 0;
	int operands_sent = 0;
	int burst_left = 0;
	logic [7:0] op_chars[$];

	asm_operand_mode_parser_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.value     (value),
		.addr_mode (addr_mode),
		.bad_char  (bad_char)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample both handshakes at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result({status, value, addr_mode, bad_char});
			if (in_valid && in_ready)
				sb.note_char(ch);
		end
	end

	// Bail out if neither channel moves for too long
	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
				idle = 0;
			else
				idle++;
		end
		$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("asm_operand_mode_parser_top_tb: FAIL");
		$finish;
	end

	// Result side: rotating stall patterns, one long hold-off
	initial begin
		int cyc;
		bit held;
		bit rdy;
		logic [7:0] pat;
		cyc = 0;
		held = 1'b0;
		pat = 8'b1011_0010;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && sb.checked >= 30) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			case ((cyc / 97) % 4)
				0: rdy = 1'b1;
				1: rdy = ($urandom_range(0, 9) < 7);
				2: rdy = pat[0];
				default: rdy = ($urandom_range(0, 3) == 0);
			endcase
			out_ready <= rdy;
			pat = {pat[6:0], pat[7]};
			cyc++;
			@(posedge clk);
		end
	end

	// Offer one word, sometimes idling between bursts
	task automatic send_char(input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		ch <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_operand(input string s);
		send_text(s);
		send_char(aomp_pkg::CH_NUL);
		operands_sent++;
	endtask

	function automatic logic [7:0] digit_char(int v);
		if (v < 10)
			return 8'(aomp_pkg::CH_0 + v);
		return 8'((($urandom_range(0, 1) != 0) ? aomp_pkg::CH_LA : aomp_pkg::CH_UA) + v - 10);
	endfunction

	function automatic logic [7:0] blank_char();
		return ($urandom_range(0, 1) != 0) ? aomp_pkg::CH_SPACE : aomp_pkg::CH_TAB;
	endfunction

	// Mostly well-formed operands with random content, some noise
	task automatic build_operand();
		int base;
		int ndig;
		int sfx;
		bit skip_tail;
		op_chars.delete();
		skip_tail = 1'b0;
		if ($urandom_range(0, 99) < 10) begin
			repeat ($urandom_range(0, 6))
				op_chars.push_back(8'($urandom_range(1, 255)));
		end else begin
			if ($urandom_range(0, 3) == 0)
				op_chars.push_back(aomp_pkg::CH_HASH);
			case ($urandom_range(0, 4))
				0: begin
					op_chars.push_back(aomp_pkg::CH_PCT);
					base = 2;
					ndig = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 18 : 9);
				end
				1: begin
					op_chars.push_back(aomp_pkg::CH_AT);
					base = 8;
					ndig = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 7 : 3);
				end
				2: begin
					op_chars.push_back(aomp_pkg::CH_DOLR);
					base = 16;
					ndig = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 5 : 3);
				end
				3: begin
					op_chars.push_back(aomp_pkg::CH_QUOTE);
					base = 0;
					ndig = 0;
					if ($urandom_range(0, 15) == 0)
						skip_tail = 1'b1;
					else
						op_chars.push_back(8'($urandom_range(1, 255)));
				end
				default: begin
					base = 10;
					op_chars.push_back(8'(aomp_pkg::CH_0 + $urandom_range(1, 9)));
					ndig = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 5 : 2);
				end
			endcase
			repeat (ndig)
				op_chars.push_back(digit_char($urandom_range(0, base - 1)));
			if (!skip_tail) begin
				// index register suffix
				sfx = $urandom_range(0, 9);
				if (sfx >= 5 && sfx <= 8) begin
					op_chars.push_back(aomp_pkg::CH_COMMA);
					if (sfx != 8) begin
						if ($urandom_range(0, 5) == 0)
							op_chars.push_back(8'($urandom_range(1, 255)));
						else
							op_chars.push_back(($urandom_range(0, 1) != 0) ?
								aomp_pkg::CH_X : aomp_pkg::CH_Y);
						if ($urandom_range(0, 7) == 0)
							op_chars.push_back(8'($urandom_range(1, 255)));
					end
				end
				// trailing blanks and junk
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) op_chars.push_back(blank_char());
				if ($urandom_range(0, 9) == 0) begin
					op_chars.push_back(8'($urandom_range(1, 255)));
					if ($urandom_range(0, 1) != 0)
						op_chars.push_back(blank_char());
				end
			end
		end
		op_chars.push_back(aomp_pkg::CH_NUL);
	endtask

	initial begin
		string directed_ops[$];
		sb = new();
		directed_ops = '{"", "#", "0", "#G", "%", "@", "$g", "#$FF", "%1011", "@777",
			"$ffff", "$FfFf", "65535", "65536", "'A", "'AB", "'", "$1FF,X", "5,Y",
			"$FF,X", "5,Z", "5,", "5,XQ", "#5,X", "12 q", "12 \t", "$100", "255", "256",
			"%10000000000000000"};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed operands: each status, each mode, corner values
		foreach (directed_ops[i])
			send_operand(directed_ops[i]);
		send_char(aomp_pkg::CH_QUOTE);
		send_char(8'hFF);
		send_char(aomp_pkg::CH_NUL);
		operands_sent++;

		// Random operands
		while (chars_sent < CHAR_TARGET) begin
			build_operand();
			foreach (op_chars[i])
				send_char(op_chars[i]);
			operands_sent++;
		end
		in_valid <= 1'b0;

		while (sb.outstanding() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("sent %0d operands in %0d characters, %0d result words checked",
			operands_sent, chars_sent, sb.checked);
		$display("status codes hit %b, good-operand modes hit %b, mismatches %0d",
			sb.status_seen, sb.mode_seen, sb.errors);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("asm_operand_mode_parser_top_tb: PASS");
		end else begin
			$display("asm_operand_mode_parser_top_tb: FAIL");
		end
		$finish;
	end

endmodule
